// ===== hw/rtl/trd_pkg.sv =====
// Shared types and constants for the terrain record deframer.
// Used by trd_core, terrain_record_deframer_unit, trd_checker, trd_result_checker and the testbench; no dependencies.
`timescale 1ns / 1ps

package trd_pkg;

	// Fixed field widths of the stream items.
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned DIM_W    = 12;
	localparam int unsigned ELEV_W   = 16;
	localparam int unsigned SUM_W    = 24;
	localparam int unsigned FOOT_W   = 32;
	localparam int unsigned CFG_IDX_W = 2;

	// Header check byte and register reset values.
	localparam logic [BYTE_W-1:0] SENTINEL_BYTE = 8'd170;
	localparam logic [DIM_W-1:0]  LAT_RESET     = 12'd1201;
	localparam logic [DIM_W-1:0]  LON_RESET     = 12'd1201;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LAT_POINTS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LON_LINES    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLE = 2'd2;

	// Part of the column record being parsed.
	typedef enum logic [1:0] {
		SEC_HEADER = 2'd0,
		SEC_ELEV   = 2'd1,
		SEC_FOOTER = 2'd2
	} section_t;

	// Result item kinds.
	typedef enum logic [1:0] {
		KIND_ELEV       = 2'd0,
		KIND_COL_GOOD   = 2'd1,
		KIND_BAD_SENT   = 2'd2,
		KIND_BAD_CHKSUM = 2'd3
	} kind_t;

	// Configuration register set.
	typedef struct packed {
		logic [DIM_W-1:0] lat_points;
		logic [DIM_W-1:0] lon_lines;
		logic             check_enable;
	} cfg_t;

	// One input item as held in the input register.
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] in_byte;
		logic              cell_start;
	} item_t;

	// One result item from the parser.
	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic [ELEV_W-1:0] elevation;
		logic [DIM_W-1:0]  col_index;
		logic [DIM_W-1:0]  row_index;
		logic              cell_done;
	} result_t;

endpackage

// ===== hw/rtl/trd_core.sv =====
// Record parser state and per-byte decode logic for the terrain record deframer.
// Depends on trd_pkg.
`timescale 1ns / 1ps

module trd_core import trd_pkg::*; #(
	parameter int unsigned COUNT_BITS = 12
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  item_t   item,
	input  logic    advance,
	output result_t res
);

	// Parser state.
	section_t              sec_q;
	logic [2:0]            pos_q;
	logic [COUNT_BITS-1:0] row_q;
	logic [COUNT_BITS-1:0] col_q;
	logic                  half_q;
	logic [BYTE_W-1:0]     high_q;
	logic                  sent_q;
	logic [SUM_W-1:0]      sum_q;
	logic [FOOT_W-1:0]     foot_q;
	logic                  halt_q;

	// State after an optional cell start clear.
	section_t              c_sec;
	logic [2:0]            c_pos;
	logic [COUNT_BITS-1:0] c_row;
	logic [COUNT_BITS-1:0] c_col;
	logic                  c_half;
	logic [BYTE_W-1:0]     c_high;
	logic                  c_sent;
	logic [SUM_W-1:0]      c_sum;
	logic [FOOT_W-1:0]     c_foot;
	logic                  c_halt;

	// Next state.
	section_t              n_sec;
	logic [2:0]            n_pos;
	logic [COUNT_BITS-1:0] n_row;
	logic [COUNT_BITS-1:0] n_col;
	logic                  n_half;
	logic [BYTE_W-1:0]     n_high;
	logic                  n_sent;
	logic [SUM_W-1:0]      n_sum;
	logic [FOOT_W-1:0]     n_foot;
	logic                  n_halt;

	logic [31:0]           lat_ext;
	logic [31:0]           lon_ext;
	logic [COUNT_BITS-1:0] lat_lim;
	logic [COUNT_BITS-1:0] lon_lim;
	logic [31:0]           row_ext;
	logic [31:0]           col_ext;
	logic [SUM_W-1:0]      sum_add;
	logic [FOOT_W-1:0]     foot_shift;
	logic [14:0]           mag;
	logic                  match;
	logic                  blocked;

	// Last-index limits, masked to the counter width.
	assign lat_ext = 32'(cfg.lat_points) - 32'd1;
	assign lon_ext = 32'(cfg.lon_lines) - 32'd1;
	assign lat_lim = lat_ext[COUNT_BITS-1:0];
	assign lon_lim = lon_ext[COUNT_BITS-1:0];

	// A cell start clears the parser before the byte is used.
	always_comb begin
		if (item.cell_start) begin
			c_sec  = SEC_HEADER;
			c_pos  = '0;
			c_row  = '0;
			c_col  = '0;
			c_half = 1'b0;
			c_high = '0;
			c_sent = 1'b0;
			c_sum  = '0;
			c_foot = '0;
			c_halt = 1'b0;
		end else begin
			c_sec  = sec_q;
			c_pos  = pos_q;
			c_row  = row_q;
			c_col  = col_q;
			c_half = half_q;
			c_high = high_q;
			c_sent = sent_q;
			c_sum  = sum_q;
			c_foot = foot_q;
			c_halt = halt_q;
		end
	end

	// Shared datapath pieces.
	assign row_ext    = 32'(c_row);
	assign col_ext    = 32'(c_col);
	assign sum_add    = c_sum + SUM_W'(item.in_byte);
	assign foot_shift = {c_foot[FOOT_W-BYTE_W-1:0], item.in_byte};
	assign mag        = {c_high[6:0], item.in_byte};
	assign match      = (foot_shift[30:0] == 31'(c_sum)) &&
		(!foot_shift[31] || (foot_shift[30:0] == 31'd0));
	assign blocked    = c_halt || (cfg.lat_points == '0) || (cfg.lon_lines == '0);

	// Next state and result for one byte.
	always_comb begin
		n_sec  = c_sec;
		n_pos  = c_pos;
		n_row  = c_row;
		n_col  = c_col;
		n_half = c_half;
		n_high = c_high;
		n_sent = c_sent;
		n_sum  = c_sum;
		n_foot = c_foot;
		n_halt = c_halt;

		res           = '0;
		res.kind      = KIND_ELEV;
		res.col_index = col_ext[DIM_W-1:0];

		if (!blocked) begin
			unique case (c_sec)
				SEC_HEADER: begin
					if (c_pos == 3'd0) begin
						n_sent = (item.in_byte == SENTINEL_BYTE);
					end
					n_sum = sum_add;
					if (c_pos == 3'd7) begin
						n_pos = '0;
						if (!n_sent) begin
							n_halt    = 1'b1;
							res.valid = 1'b1;
							res.kind  = KIND_BAD_SENT;
						end else begin
							n_sec  = SEC_ELEV;
							n_row  = '0;
							n_half = 1'b0;
						end
					end else begin
						n_pos = c_pos + 3'd1;
					end
				end
				SEC_ELEV: begin
					n_sum = sum_add;
					if (!c_half) begin
						n_high = item.in_byte;
						n_half = 1'b1;
					end else begin
						// Sign-magnitude to two's complement; negative zero gives zero.
						n_half        = 1'b0;
						res.valid     = 1'b1;
						res.kind      = KIND_ELEV;
						res.elevation = c_high[7] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
						res.row_index = row_ext[DIM_W-1:0];
						if (c_row == lat_lim) begin
							n_sec  = SEC_FOOTER;
							n_pos  = '0;
							n_row  = '0;
							n_foot = '0;
						end else begin
							n_row = c_row + 1'b1;
						end
					end
				end
				SEC_FOOTER: begin
					n_foot = foot_shift;
					if (c_pos < 3'd3) begin
						n_pos = c_pos + 3'd1;
					end else begin
						n_pos     = '0;
						n_sec     = SEC_HEADER;
						res.valid = 1'b1;
						if (cfg.check_enable && !match) begin
							n_halt   = 1'b1;
							res.kind = KIND_BAD_CHKSUM;
						end else begin
							res.kind      = KIND_COL_GOOD;
							res.cell_done = (c_col == lon_lim);
							n_halt        = c_halt || (c_col == lon_lim);
							n_col         = c_col + 1'b1;
							n_sum         = '0;
							n_foot        = '0;
						end
					end
				end
				default: begin
					res.valid = 1'b0;
				end
			endcase
		end

		if (!item.valid) begin
			res.valid = 1'b0;
		end
	end

	// State registers update when the held item moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q  <= SEC_HEADER;
			pos_q  <= '0;
			row_q  <= '0;
			col_q  <= '0;
			half_q <= 1'b0;
			high_q <= '0;
			sent_q <= 1'b0;
			sum_q  <= '0;
			foot_q <= '0;
			halt_q <= 1'b0;
		end else if (advance && item.valid) begin
			sec_q  <= n_sec;
			pos_q  <= n_pos;
			row_q  <= n_row;
			col_q  <= n_col;
			half_q <= n_half;
			high_q <= n_high;
			sent_q <= n_sent;
			sum_q  <= n_sum;
			foot_q <= n_foot;
			halt_q <= n_halt;
		end
	end

endmodule

// ===== hw/rtl/terrain_record_deframer_unit.sv =====
// A byte accepted into the input register is decoded combinationally and its result item
// is written to the result register, unless a stalled result item holds the pipeline.
// Throughput: one byte per cycle while the result side is ready; when a result item
// waits, the input register takes one more byte and then the input stalls.
// Reset (arst_n low, asynchronous): parser state cleared to the header section,
// no item held, registers back to 1201 / 1201 / checking on.
// Top level of the terrain record deframer; depends on trd_pkg and trd_core.
`timescale 1ns / 1ps

module terrain_record_deframer_unit import trd_pkg::*; #(
	parameter int unsigned COUNT_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Byte stream in.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] in_byte
	input  logic                 s_tuser,   // [0] cell_start
	// Result stream out.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [39:0]          m_tdata,   // [15:0] elevation, [27:16] col_index,
	                                        // [39:28] row_index
	output logic [1:0]           m_tuser,   // [1:0] kind
	output logic                 m_tlast,   // cell_done
	// Register writes.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	cfg_t    cfg_q;
	item_t   item_s1;
	result_t res;
	result_t out_q;
	logic    advance;

	// Register writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lat_points   <= LAT_RESET;
			cfg_q.lon_lines    <= LON_RESET;
			cfg_q.check_enable <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_LAT_POINTS:   cfg_q.lat_points   <= cfg_data;
				CFG_LON_LINES:    cfg_q.lon_lines    <= cfg_data;
				CFG_CHECK_ENABLE: cfg_q.check_enable <= cfg_data[0];
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	// The held item moves on whenever the result register is free or being drained.
	assign advance  = !out_q.valid || m_tready;
	assign s_tready = !item_s1.valid || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (s_tvalid && s_tready) begin
			item_s1.valid      <= 1'b1;
			item_s1.in_byte    <= s_tdata;
			item_s1.cell_start <= s_tuser;
		end else if (advance) begin
			item_s1.valid <= 1'b0;
		end
	end

	trd_core #(
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.item    (item_s1),
		.advance (advance),
		.res     (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (advance && res.valid) begin
			out_q <= res;
		end else if (advance) begin
			out_q.valid <= 1'b0;
		end
	end

	assign m_tvalid = out_q.valid;
	assign m_tdata  = {out_q.row_index, out_q.col_index, out_q.elevation};
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.cell_done;

endmodule

// ===== hw/rtl/trd_checker.sv =====
// Port-level assertions for the terrain record deframer, bound to its top level.
// Depends on trd_pkg.
`timescale 1ns / 1ps

module trd_checker import trd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// A stalled result item holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result item changed while stalled");

	// The end of the cell is flagged only on a good column status.
	a_done_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == KIND_COL_GOOD)
		else $error("cell_done on a result that is not a good column");

	// Status items carry no elevation and no row.
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != KIND_ELEV) |-> m_tdata[15:0] == 16'd0
			&& m_tdata[39:28] == 12'd0)
		else $error("status item carries elevation or row");

	// A 15-bit magnitude never decodes to the most negative code.
	a_elev_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:0] != 16'h8000)
		else $error("elevation out of range");

endmodule

bind terrain_record_deframer_unit trd_checker u_trd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ===== tb/trd_result_checker.sv =====
// Result checker for the terrain record deframer: predicts the result items from the
// accepted bytes and register writes, and compares them with the result stream.
// Depends on trd_pkg for field widths, register indexes, sections and result kinds.
`timescale 1ns / 1ps

module trd_result_checker import trd_pkg::*; #(
	parameter int unsigned COUNT_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [7:0]           s_tdata,
	input  logic                 s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [39:0]          m_tdata,
	input  logic [1:0]           m_tuser,
	input  logic                 m_tlast,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	output int                   results_due,
	output int                   mismatch_count
);

	// One decoded result item, as predicted or as seen on the result stream.
	typedef struct packed {
		kind_t             kind;
		logic [ELEV_W-1:0] elevation;
		logic [DIM_W-1:0]  col_index;
		logic [DIM_W-1:0]  row_index;
		logic              cell_done;
	} deframed_t;

	deframed_t deframed_due [$];
	deframed_t seen;
	deframed_t want;
	int        errors = 0;

	// Register copies.
	logic [DIM_W-1:0] lat_points;
	logic [DIM_W-1:0] lon_lines;
	logic             check_enable;

	// Parser state.
	section_t               section;
	logic [2:0]             byte_pos;
	logic [COUNT_BITS-1:0]  row_count;
	logic [COUNT_BITS-1:0]  col_count;
	logic                   second_half;
	logic [BYTE_W-1:0]      held_high;
	logic                   sentinel_ok;
	logic [SUM_W-1:0]       byte_sum;
	logic [FOOT_W-1:0]      footer_word;
	logic                   halted;

	assign mismatch_count = errors;

	task automatic clear_parser();
		section     = SEC_HEADER;
		byte_pos    = '0;
		row_count   = '0;
		col_count   = '0;
		second_half = 1'b0;
		held_high   = '0;
		sentinel_ok = 1'b0;
		byte_sum    = '0;
		footer_word = '0;
		halted      = 1'b0;
	endtask

	// Every result carries the column record it belongs to.
	task automatic queue_result(input kind_t kind, input logic [ELEV_W-1:0] elev,
			input logic [DIM_W-1:0] row, input logic done);
		deframed_due.push_back('{kind: kind, elevation: elev, col_index: DIM_W'(col_count),
			row_index: row, cell_done: done});
	endtask

	// Advances the parser by one accepted byte and queues the result it causes.
	task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic start);
		logic [ELEV_W-1:0]     mag;
		logic [COUNT_BITS-1:0] row_last;
		logic [COUNT_BITS-1:0] col_last;
		logic [30:0]           foot_mag;
		logic                  sum_ok;
		logic                  last_col;
		row_last = COUNT_BITS'(32'(lat_points) - 32'd1);
		col_last = COUNT_BITS'(32'(lon_lines) - 32'd1);
		if (start)
			clear_parser();
		// A halted parser or an empty cell ignores the byte entirely.
		if (halted || lat_points == '0 || lon_lines == '0)
			return;
		case (section)
		SEC_HEADER: begin
			if (byte_pos == 3'd0)
				sentinel_ok = (b == SENTINEL_BYTE);
			byte_sum = byte_sum + SUM_W'(b);
			if (byte_pos == 3'd7) begin
				byte_pos = '0;
				if (!sentinel_ok) begin
					halted = 1'b1;
					queue_result(KIND_BAD_SENT, '0, '0, 1'b0);
				end else begin
					section     = SEC_ELEV;
					row_count   = '0;
					second_half = 1'b0;
				end
			end else begin
				byte_pos = byte_pos + 3'd1;
			end
		end
		SEC_ELEV: begin
			byte_sum = byte_sum + SUM_W'(b);
			if (!second_half) begin
				held_high   = b;
				second_half = 1'b1;
			end else begin
				// Sign-magnitude to two's complement; negative zero becomes zero.
				second_half = 1'b0;
				mag = {1'b0, held_high[6:0], b};
				queue_result(KIND_ELEV, held_high[7] ? ELEV_W'(0) - mag : mag,
					DIM_W'(row_count), 1'b0);
				if (row_count == row_last) begin
					section     = SEC_FOOTER;
					byte_pos    = '0;
					row_count   = '0;
					footer_word = '0;
				end else begin
					row_count = row_count + 1'b1;
				end
			end
		end
		SEC_FOOTER: begin
			footer_word = {footer_word[23:0], b};
			if (byte_pos != 3'd3) begin
				byte_pos = byte_pos + 3'd1;
			end else begin
				// A footer with its sign set only matches as negative zero against a zero sum.
				byte_pos = '0;
				section  = SEC_HEADER;
				foot_mag = footer_word[30:0];
				sum_ok   = (foot_mag == 31'(byte_sum)) && (!footer_word[31] || foot_mag == '0);
				if (check_enable && !sum_ok) begin
					halted = 1'b1;
					queue_result(KIND_BAD_CHKSUM, '0, '0, 1'b0);
				end else begin
					last_col = (col_count == col_last);
					queue_result(KIND_COL_GOOD, '0, '0, last_col);
					if (last_col)
						halted = 1'b1;
					col_count   = col_count + 1'b1;
					byte_sum    = '0;
					footer_word = '0;
				end
			end
		end
		default: ;
		endcase
	endtask

	task automatic check_field(input string name, input int want_val, input int got_val);
		if (want_val != got_val) begin
			$error("%s: expected %0d, actual %0d", name, want_val, got_val);
			errors++;
		end
	endtask

	// Compare results first, then apply register writes and accepted bytes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_points   = LAT_RESET;
			lon_lines    = LON_RESET;
			check_enable = 1'b1;
			clear_parser();
			deframed_due.delete();
			results_due <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen = '{kind: kind_t'(m_tuser), elevation: m_tdata[15:0],
					col_index: m_tdata[27:16], row_index: m_tdata[39:28], cell_done: m_tlast};
				if (deframed_due.size() == 0) begin
					$error("unexpected result item: kind %0d, col %0d", seen.kind, seen.col_index);
					errors++;
				end else begin
					want = deframed_due.pop_front();
					check_field("kind", int'(want.kind), int'(seen.kind));
					check_field("elevation", int'($signed(want.elevation)),
						int'($signed(seen.elevation)));
					check_field("col_index", int'(want.col_index), int'(seen.col_index));
					check_field("row_index", int'(want.row_index), int'(seen.row_index));
					check_field("cell_done", int'(want.cell_done), int'(seen.cell_done));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_LAT_POINTS:   lat_points   = cfg_data;
				CFG_LON_LINES:    lon_lines    = cfg_data;
				CFG_CHECK_ENABLE: check_enable = cfg_data[0];
				default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				parse_byte(s_tdata, s_tuser);
			results_due <= deframed_due.size();
		end
	end

endmodule

// ===== tb/terrain_record_deframer_unit_tb.sv =====
// Testbench top for the terrain record deframer: drives cells of column records,
// register settings and back-pressure, and gives the verdict.
// Depends on trd_pkg, terrain_record_deframer_unit and trd_result_checker.
`timescale 1ns / 1ps

module terrain_record_deframer_unit_tb;
	import trd_pkg::*;

	localparam int unsigned COUNT_BITS  = 12;
	localparam int          TAIL_CYCLES = 6;
	localparam int          CYCLE_LIMIT = 1_000_000;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata   = '0;   // [7:0] in_byte
	logic                 s_tuser   = 1'b0; // [0] cell_start
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [39:0]          m_tdata;          // [15:0] elevation, [27:16] col_index,
	                                        // [39:28] row_index
	logic [1:0]           m_tuser;          // [1:0] kind
	logic                 m_tlast;          // cell_done
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0]     cfg_data  = '0;
	int                   results_due;
	int                   mismatch_count;

	int               send_idle = 7;
	int               recv_idle = 83;
	int               sent      = 0;
	int               cycles    = 0;
	logic [DIM_W-1:0] lat_cfg;
	logic [DIM_W-1:0] lon_cfg;
	logic             chk_cfg;
	logic [8:0]       opening [23];

	terrain_record_deframer_unit #(.COUNT_BITS(COUNT_BITS)) i_dut (.*);

	trd_result_checker #(.COUNT_BITS(COUNT_BITS)) u_checker (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver back-pressure.
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle);

	// Run limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Offers one byte, with random gaps ahead of it, and waits until it is taken.
	task automatic push_byte(input logic [7:0] b, input logic start);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= start;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
	endtask

	// Stops sending until every predicted result has come and the pipeline is empty.
	task automatic settle();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (results_due != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic configure(input logic [DIM_W-1:0] lat, input logic [DIM_W-1:0] lon,
			input logic chk);
		settle();
		write_reg(CFG_LAT_POINTS, lat);
		write_reg(CFG_LON_LINES, lon);
		write_reg(CFG_CHECK_ENABLE, DIM_W'(chk));
		cfg_valid <= 1'b0;
		lat_cfg = lat;
		lon_cfg = lon;
		chk_cfg = chk;
	endtask

	task automatic send_noise(input int count);
		for (int i = 0; i < count; i++)
			push_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
	endtask

	// Sends one cell of column records. Unless clean, a record may lose its sentinel,
	// carry a wrong checksum or be cut short; the cell ends where the block would halt.
	task automatic send_cell(input int stop_at, input bit clean);
		int               n;
		int               cut;
		int               pick;
		logic [SUM_W-1:0] sum;
		logic [31:0]      foot;
		logic [7:0]       hi;
		logic [7:0]       lo;
		logic [7:0]       b;
		bit               bad_head;
		n   = 0;
		cut = (!clean && $urandom_range(9) == 0) ? $urandom_range(1, 60) : 0;
		for (int col = 0; col < lon_cfg && sent < stop_at; col++) begin
			sum      = '0;
			bad_head = !clean && $urandom_range(19) == 0;
			for (int k = 0; k < 8; k++) begin
				b = 8'($urandom_range(255));
				if (k == 0)
					b = bad_head ? ((b == SENTINEL_BYTE) ? ~b : b) : SENTINEL_BYTE;
				push_byte(b, n == 0);
				sum = sum + SUM_W'(b);
				n++;
				if (cut > 0 && n >= cut)
					return;
			end
			if (bad_head)
				return;
			// Elevations, with the magnitude extremes and negative zero mixed in.
			for (int row = 0; row < lat_cfg; row++) begin
				pick = $urandom_range(15);
				case (pick)
				0:       begin hi = 8'h7F; lo = 8'hFF; end
				1:       begin hi = 8'hFF; lo = 8'hFF; end
				2:       begin hi = 8'h80; lo = 8'h00; end
				3:       begin hi = 8'h00; lo = 8'h00; end
				default: begin hi = 8'($urandom_range(255)); lo = 8'($urandom_range(255)); end
				endcase
				push_byte(hi, 1'b0);
				push_byte(lo, 1'b0);
				sum = sum + SUM_W'(hi) + SUM_W'(lo);
				n += 2;
				if (cut > 0 && n >= cut)
					return;
			end
			// Footer: mostly the true sum, sometimes signed, random or with one bit off.
			pick = clean ? 19 : $urandom_range(19);
			case (pick)
			0:       foot = {1'b1, 7'd0, sum};
			1, 2:    foot = $urandom();
			3:       foot = {8'd0, sum} ^ (32'd1 << $urandom_range(31));
			default: foot = {8'd0, sum};
			endcase
			for (int k = 3; k >= 0; k--)
				push_byte(foot[8*k +: 8], 1'b0);
			n += 4;
			if (chk_cfg && foot != {8'd0, sum})
				return;
		end
	endtask

	task automatic run_traffic(input int count);
		int stop_at;
		stop_at = sent + count;
		while (sent < stop_at) begin
			if ($urandom_range(9) == 0)
				send_noise($urandom_range(1, 5));
			else
				send_cell(stop_at, 1'b0);
		end
	endtask

	initial begin
		// One point per column, one column: a negative-zero elevation with a good
		// checksum ends the cell, a byte while halted, then a cell with a bad sentinel.
		opening = '{9'h1AA, 9'h000, 9'h0FF, 9'h001, 9'h002, 9'h004, 9'h008, 9'h010,
			9'h080, 9'h000, 9'h000, 9'h000, 9'h002, 9'h048,
			9'h0AA,
			9'h155, 9'h0FF, 9'h07F, 9'h080, 9'h001, 9'h0FE, 9'h000, 9'h0C3};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(12'd1, 12'd1, 1'b1);
		foreach (opening[i])
			push_byte(opening[i][7:0], opening[i][8]);

		// Sender nearly always ready, receiver mostly stalled.
		configure(12'd3, 12'd2, 1'b1);
		run_traffic(250);
		configure(12'd2, 12'd4095, 1'b0);
		run_traffic(120);

		// Sender mostly idle, receiver nearly always ready.
		send_idle = 83;
		recv_idle = 7;
		configure(12'd4, 12'd3, 1'b1);
		run_traffic(250);

		// Empty cells: every byte is ignored.
		configure(12'd0, 12'd2, 1'b1);
		send_noise(8);
		configure(12'd2, 12'd0, 1'b1);
		send_noise(8);

		// No idling on either side, including one long column record.
		send_idle = 0;
		recv_idle = 0;
		configure(12'd80, 12'd1, 1'b1);
		send_cell(sent + 1000, 1'b1);
		configure(12'd1, 12'd3, 1'b0);
		run_traffic(150);
		configure(12'd5, 12'd1, 1'b1);
		run_traffic(100);

		settle();
		if (mismatch_count == 0 && results_due == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/trd_pkg.sv
hw/rtl/trd_core.sv
hw/rtl/terrain_record_deframer_unit.sv
hw/rtl/trd_checker.sv
tb/trd_result_checker.sv
tb/terrain_record_deframer_unit_tb.sv
